// ===== rtl/iprt_pkg.sv =====
// Package for the address range table lookup block.
// Holds table sizing constants, transaction structs, and state encodings.
// Has no dependencies and is compiled first.
`default_nettype none

package iprt_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int ENTRY_W = 12;
	localparam int COUNT_W = 13;
	localparam int ADDR_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t req_type;
		logic [ENTRY_W-1:0] entry_index;
		logic [ADDR_W-1:0] range_start;
		logic [ADDR_W-1:0] range_end;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [ENTRY_W-1:0] match_index;
	} res_t;

	typedef struct packed {
		req_kind_t kind;
		logic wr_ok;
		logic [IDX_W-1:0] idx;
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] last_addr;
		logic [ADDR_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] last_addr;
	} entry_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_REPORT
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/iprt_front.sv =====
// Front end of the range table lookup: accepts requests, classifies them into
// commands, and holds them in a short queue for the back end.
// Depends on iprt_pkg.
`default_nettype none

module iprt_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire iprt_pkg::req_t req,
	output iprt_pkg::queue_out_t q_out,
	input wire logic q_pop
);

	iprt_pkg::cmd_t slot_q [iprt_pkg::QUEUE_DEPTH];
	logic [iprt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [iprt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [iprt_pkg::QFILL_W-1:0] fill_q;
	iprt_pkg::cmd_t cmd;
	logic push;
	logic pop;

	assign busy = (fill_q == iprt_pkg::QFILL_W'(iprt_pkg::QUEUE_DEPTH));
	assign push = start && !busy;
	assign pop = q_pop && (fill_q != '0);

	always_comb begin
		cmd.kind = req.req_type;
		cmd.wr_ok = (32'(req.entry_index) < 32'(iprt_pkg::TABLE_DEPTH));
		cmd.idx = iprt_pkg::IDX_W'(req.entry_index);
		cmd.first_addr = req.range_start;
		cmd.last_addr = req.range_end;
		cmd.key = req.address;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign q_out.valid = (fill_q != '0);
	assign q_out.cmd = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/iprt_back.sv =====
// Back end of the range table lookup: owns the range table memory, performs
// loads, and runs the binary search with one table read per cycle.
// Depends on iprt_pkg.
`default_nettype none

module iprt_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [iprt_pkg::CNT_W-1:0] active_count,
	input wire iprt_pkg::queue_out_t q_in,
	output logic q_pop,
	output logic done,
	output iprt_pkg::res_t result
);

	iprt_pkg::entry_t mem [iprt_pkg::TABLE_DEPTH];
	iprt_pkg::entry_t rd_q;
	iprt_pkg::back_state_t state_q;
	iprt_pkg::back_state_t state_nx;

	logic [iprt_pkg::CNT_W-1:0] lo_q;
	logic [iprt_pkg::CNT_W-1:0] len_q;
	logic [iprt_pkg::CNT_W-1:0] n_q;
	logic [iprt_pkg::ADDR_W-1:0] key_q;
	logic [iprt_pkg::ADDR_W-1:0] lt_last_q;
	logic [iprt_pkg::ADDR_W-1:0] ge_first_q;
	logic [iprt_pkg::ADDR_W-1:0] ge_last_q;
	logic done_q;
	iprt_pkg::res_t result_q;

	logic [iprt_pkg::CNT_W-1:0] half;
	logic [iprt_pkg::CNT_W-1:0] mid;
	logic go_right;
	logic [iprt_pkg::CNT_W-1:0] lo_nx;
	logic [iprt_pkg::CNT_W-1:0] len_nx;
	logic [iprt_pkg::CNT_W-1:0] lo_sel;
	logic [iprt_pkg::CNT_W-1:0] len_sel;
	logic [iprt_pkg::CNT_W-1:0] rd_pos;
	logic rd_en;
	logic wr_en;
	logic seed;
	logic step;
	logic report;
	logic cand_eq;
	logic hit_c;
	logic [iprt_pkg::CNT_W-1:0] cand;

	function automatic logic q_pin_lookup();
		return q_in.valid && (q_in.cmd.kind == iprt_pkg::REQ_LOOKUP);
	endfunction

	assign half = len_q >> 1;
	assign mid = lo_q + half;
	assign go_right = (rd_q.first_addr < key_q);
	assign lo_nx = go_right ? (mid + 1'b1) : lo_q;
	assign len_nx = go_right ? (len_q - half - 1'b1) : half;
	assign lo_sel = seed ? '0 : lo_nx;
	assign len_sel = seed ? active_count : len_nx;
	assign rd_pos = lo_sel + (len_sel >> 1);

	always_comb begin
		state_nx = state_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		seed = 1'b0;
		step = 1'b0;
		report = 1'b0;
		unique case (state_q)
			iprt_pkg::ST_IDLE: begin
				seed = 1'b1;
				if (q_in.valid) begin
					q_pop = 1'b1;
					if (q_in.cmd.kind == iprt_pkg::REQ_LOAD) begin
						wr_en = q_in.cmd.wr_ok;
					end else if (active_count == '0) begin
						state_nx = iprt_pkg::ST_REPORT;
					end else begin
						rd_en = 1'b1;
						state_nx = iprt_pkg::ST_SEARCH;
					end
				end
			end
			iprt_pkg::ST_SEARCH: begin
				step = 1'b1;
				if (len_nx == '0) begin
					state_nx = iprt_pkg::ST_REPORT;
				end else begin
					rd_en = 1'b1;
				end
			end
			iprt_pkg::ST_REPORT: begin
				report = 1'b1;
				state_nx = iprt_pkg::ST_IDLE;
			end
			default: begin
				state_nx = iprt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iprt_pkg::ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[q_in.cmd.idx] <= '{first_addr: q_in.cmd.first_addr,
				last_addr: q_in.cmd.last_addr};
		end
		if (rd_en) begin
			rd_q <= mem[rd_pos[iprt_pkg::IDX_W-1:0]];
		end
	end

	// The final lower bound equals the last mid that moved the upper edge, and
	// the entry just below it is the last mid that moved the lower edge.
	always_ff @(posedge clk) begin
		if (seed && q_pin_lookup()) begin
			lo_q <= '0;
			len_q <= active_count;
			n_q <= active_count;
			key_q <= q_in.cmd.key;
		end else if (step) begin
			lo_q <= lo_nx;
			len_q <= len_nx;
			if (go_right) begin
				lt_last_q <= rd_q.last_addr;
			end else begin
				ge_first_q <= rd_q.first_addr;
				ge_last_q <= rd_q.last_addr;
			end
		end
	end

	always_comb begin
		cand_eq = (lo_q < n_q) && (ge_first_q == key_q);
		if (cand_eq) begin
			hit_c = (key_q <= ge_last_q);
			cand = lo_q;
		end else begin
			hit_c = (lo_q != '0) && (key_q <= lt_last_q);
			cand = lo_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			result_q.hit <= hit_c;
			result_q.match_index <= hit_c ? iprt_pkg::ENTRY_W'(cand[iprt_pkg::IDX_W-1:0]) : '0;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/ip_range_table_lookup.sv =====
// Top level of the address range table lookup block.
// Holds the range count register and connects front end, queue and back end.
// Depends on iprt_pkg, iprt_front and iprt_back.
`default_nettype none

// A transaction is accepted when start is high and busy is low. A load
// transaction writes one table entry and produces no result; a lookup
// transaction produces one result, shown for exactly one cycle with done high,
// and the receiver cannot stall it. A lookup, once it leaves the queue, is
// served by the binary search, which makes one read of the single-port table
// memory per cycle; a load is written as it leaves the queue. A two-entry
// queue lets new transactions be accepted while a search runs. Write
// range_count only while the block is idle.
module ip_range_table_lookup (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire iprt_pkg::req_t req,
	input wire logic cfg_we,
	input wire logic [iprt_pkg::COUNT_W-1:0] cfg_wdata,
	output logic done,
	output iprt_pkg::res_t result
);

	logic [iprt_pkg::COUNT_W-1:0] range_count_q;
	logic [iprt_pkg::CNT_W-1:0] active_count;
	iprt_pkg::queue_out_t q_out;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q <= '0;
		end else if (cfg_we) begin
			range_count_q <= cfg_wdata;
		end
	end

	assign active_count = (32'(range_count_q) > 32'(iprt_pkg::TABLE_DEPTH))
		? iprt_pkg::CNT_W'(iprt_pkg::TABLE_DEPTH)
		: iprt_pkg::CNT_W'(range_count_q);

	iprt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.q_out(q_out),
		.q_pop(q_pop)
	);

	iprt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.active_count(active_count),
		.q_in(q_out),
		.q_pop(q_pop),
		.done(done),
		.result(result)
	);

endmodule

`default_nettype wire

// ===== verif/ip_range_table_lookup_tb.sv =====
// Self-checking testbench for ip_range_table_lookup: loads sorted and scrambled range tables,
// looks up addresses, and checks every result against a binary search kept in a scoreboard.
// Depends on iprt_pkg and the ip_range_table_lookup RTL.
module ip_range_table_lookup_tb;

	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 85;
	localparam int PHASES = 10;
	localparam int SPINE_ITEMS = 40;
	localparam logic [31:0] SPINE_BASE = 32'h0000_1000;
	localparam longint SPINE_STEP = 64'h1_0000_0000 / iprt_pkg::TABLE_DEPTH;

	class range_table_scoreboard;
		logic [iprt_pkg::ADDR_W-1:0] first_addr[iprt_pkg::TABLE_DEPTH];
		logic [iprt_pkg::ADDR_W-1:0] last_addr[iprt_pkg::TABLE_DEPTH];
		logic [iprt_pkg::COUNT_W-1:0] range_count;
		iprt_pkg::res_t expected_matches[$];
		int errors;

		function new();
			range_count = '0;
			errors = 0;
		endfunction

		function void set_range_count(logic [iprt_pkg::COUNT_W-1:0] value);
			range_count = value;
		endfunction

		function int active_entries();
			return (range_count > iprt_pkg::TABLE_DEPTH) ? iprt_pkg::TABLE_DEPTH
				: int'(range_count);
		endfunction

		function iprt_pkg::res_t search(logic [iprt_pkg::ADDR_W-1:0] key);
			int n;
			int lo;
			int len;
			int half;
			int cand;
			bit found;
			iprt_pkg::res_t r;
			n = active_entries();
			lo = 0;
			len = n;
			while (len > 0) begin
				half = len >> 1;
				if (first_addr[lo + half] < key) begin
					lo = lo + half + 1;
					len = len - half - 1;
				end else begin
					len = half;
				end
			end
			found = 1'b0;
			cand = 0;
			if (lo < n && first_addr[lo] == key) begin
				cand = lo;
				found = 1'b1;
			end else if (lo > 0) begin
				cand = lo - 1;
				found = 1'b1;
			end
			r.hit = found && first_addr[cand] <= key && key <= last_addr[cand];
			r.match_index = r.hit ? cand[iprt_pkg::ENTRY_W-1:0] : '0;
			return r;
		endfunction

		function void note_request(iprt_pkg::req_t r);
			if (r.req_type == iprt_pkg::REQ_LOAD) begin
				first_addr[r.entry_index] = r.range_start;
				last_addr[r.entry_index] = r.range_end;
			end else begin
				expected_matches.push_back(search(r.address));
			end
		endfunction

		function void fail(string msg);
			errors++;
			$error("%s", msg);
		endfunction

		function void check_match(iprt_pkg::res_t got);
			iprt_pkg::res_t want;
			if (expected_matches.size() == 0) begin
				fail($sformatf("result with no lookup outstanding: hit %0d, match_index %0d",
					got.hit, got.match_index));
				return;
			end
			want = expected_matches.pop_front();
			if (got.hit !== want.hit) begin
				fail($sformatf("hit: expected %0d, actual %0d", want.hit, got.hit));
			end
			if (got.match_index !== want.match_index) begin
				fail($sformatf("match_index: expected %0d, actual %0d",
					want.match_index, got.match_index));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	iprt_pkg::req_t req = '0;
	logic cfg_we = 1'b0;
	logic [iprt_pkg::COUNT_W-1:0] cfg_wdata = '0;
	logic done;
	iprt_pkg::res_t result;
	bit no_gaps = 1'b0;
	range_table_scoreboard sb = new();

	ip_range_table_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			sb.check_match(result);
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send(input iprt_pkg::req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(r);
	endtask

	task automatic send_load(input logic [iprt_pkg::ENTRY_W-1:0] idx,
			input logic [iprt_pkg::ADDR_W-1:0] s, input logic [iprt_pkg::ADDR_W-1:0] e);
		iprt_pkg::req_t r;
		r.req_type = iprt_pkg::REQ_LOAD;
		r.entry_index = idx;
		r.range_start = s;
		r.range_end = e;
		r.address = $urandom;
		send(r);
	endtask

	task automatic send_lookup(input logic [iprt_pkg::ADDR_W-1:0] addr);
		iprt_pkg::req_t r;
		r.req_type = iprt_pkg::REQ_LOOKUP;
		r.entry_index = iprt_pkg::ENTRY_W'($urandom);
		r.range_start = $urandom;
		r.range_end = $urandom;
		r.address = addr;
		send(r);
	endtask

	task automatic write_range_count(input logic [iprt_pkg::COUNT_W-1:0] value);
		start <= 1'b0;
		while (sb.expected_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_range_count(value);
	endtask

	task automatic load_sorted_table(input int n);
		longint unsigned span;
		longint unsigned pos;
		longint unsigned last;
		span = 64'h1_0000_0000 / (n + 1);
		pos = $urandom_range(0, 32'(span));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) != 0) begin
				pos = pos + $urandom_range(1, 32'(span)) + $urandom_range(0, 32'(span));
			end
			if (pos > 64'hFFFF_FFFF) begin
				pos = 64'hFFFF_FFFF;
			end
			last = pos + $urandom_range(0, 32'(span));
			if (last > 64'hFFFF_FFFF) begin
				last = 64'hFFFF_FFFF;
			end
			if ($urandom_range(0, 15) == 0 && pos > 0) begin
				last = pos - 1;
			end
			send_load(i[iprt_pkg::ENTRY_W-1:0], pos[iprt_pkg::ADDR_W-1:0],
				last[iprt_pkg::ADDR_W-1:0]);
		end
	endtask

	function automatic logic [iprt_pkg::ADDR_W-1:0] pick_address(input int n);
		int i;
		if (n == 0) begin
			return $urandom;
		end
		i = $urandom_range(0, n - 1);
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return sb.first_addr[i];
			3: return sb.last_addr[i];
			4: return sb.last_addr[i] + 1;
			5: return sb.first_addr[i] - 1;
			6: return sb.first_addr[i] + (sb.last_addr[i] - sb.first_addr[i]) / 2;
			default: return $urandom_range(0, 1) ? '0 : '1;
		endcase
	endfunction

	task automatic run_lookups(input int items);
		int n;
		int i;
		n = sb.active_entries();
		repeat (items) begin
			if ($urandom_range(0, 9) == 0) begin
				if (n > 0 && $urandom_range(0, 1) == 1) begin
					i = $urandom_range(0, n - 1);
					send_load(i[iprt_pkg::ENTRY_W-1:0], sb.first_addr[i], $urandom);
				end else begin
					send_load(iprt_pkg::ENTRY_W'($urandom), $urandom, $urandom);
				end
			end else begin
				send_lookup(pick_address(n));
			end
		end
	endtask

	// A full-depth search for an address below every start or above every
	// start only reads the entries on the leftmost or rightmost search path.
	function automatic logic [iprt_pkg::ADDR_W-1:0] spine_start(input int i);
		return iprt_pkg::ADDR_W'(longint'(i) * SPINE_STEP + longint'(SPINE_BASE));
	endfunction

	task automatic send_spine_entry(input int i);
		logic [iprt_pkg::ADDR_W-1:0] s;
		s = spine_start(i);
		send_load(i[iprt_pkg::ENTRY_W-1:0], s,
			s + iprt_pkg::ADDR_W'($urandom_range(0, 32'h00FF_FFFF)));
	endtask

	task automatic load_spines();
		int lo;
		int len;
		int half;
		send_spine_entry(0);
		for (int b = 1; b < iprt_pkg::TABLE_DEPTH; b = b * 2) begin
			send_spine_entry(b);
		end
		lo = 0;
		len = iprt_pkg::TABLE_DEPTH;
		while (len > 0) begin
			half = len >> 1;
			send_spine_entry(lo + half);
			lo = lo + half + 1;
			len = len - half - 1;
		end
	endtask

	task automatic run_spine_lookups(input int items);
		send_lookup(SPINE_BASE);
		send_lookup(spine_start(iprt_pkg::TABLE_DEPTH - 1));
		repeat (items) begin
			if ($urandom_range(0, 1) == 0) begin
				send_lookup($urandom_range(0, SPINE_BASE));
			end else begin
				send_lookup($urandom_range(spine_start(iprt_pkg::TABLE_DEPTH - 1),
					32'hFFFF_FFFF));
			end
		end
	endtask

	initial begin
		int phase_entries[PHASES] = '{1, 2, 3, 7, 31, 64, 200, 0, 5, 12};
		int phase_count[PHASES] = '{1, 2, 3, 7, 31, 40, 200, 0, 5, 12};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_load(12'd0, 32'h0000_0000, 32'h0000_0010);
		send_load(12'd1, 32'h0000_0100, 32'h0000_01FF);
		send_load(12'd2, 32'h0000_0100, 32'h0000_02FF);
		send_load(12'd3, 32'h8000_0000, 32'h7FFF_FFFF);
		send_load(12'd4, 32'h9000_0000, 32'hA000_0000);
		send_load(12'd5, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		write_range_count(13'd6);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0010);
		send_lookup(32'h0000_0011);
		send_lookup(32'h0000_0100);
		send_lookup(32'h0000_0250);
		send_lookup(32'h8000_0000);
		send_lookup(32'h9000_0000);
		send_lookup(32'hA000_0001);
		send_lookup(32'hFFFF_FFFF);
		send_lookup(32'hFFFF_FFEF);
		send_load(12'd0, 32'h0000_0020, 32'h0000_0030);
		send_lookup(32'h0000_0005);

		for (int p = 0; p < PHASES; p++) begin
			no_gaps = (p % 4 == 2);
			if (phase_entries[p] > 0) begin
				write_range_count(13'd0);
				load_sorted_table(phase_entries[p]);
			end
			write_range_count(iprt_pkg::COUNT_W'(phase_count[p]));
			run_lookups(PHASE_ITEMS);
		end

		no_gaps = 1'b0;
		load_spines();
		write_range_count(13'h1FFF);
		run_spine_lookups(SPINE_ITEMS);
		write_range_count(iprt_pkg::COUNT_W'(iprt_pkg::TABLE_DEPTH));
		run_spine_lookups(SPINE_ITEMS);

		start <= 1'b0;
		while (sb.expected_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/iprt_pkg.sv
rtl/iprt_front.sv
rtl/iprt_back.sv
rtl/ip_range_table_lookup.sv
verif/ip_range_table_lookup_tb.sv
